>>> design/rblc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the rev bar color table for the LED refresh controller.
// No dependencies; imported by every module of the block.
package rblc_pkg;

	localparam int NUM_LEDS  = 15;
	localparam int LED_IDX_W = $clog2(NUM_LEDS);
	localparam int JOB_DEPTH = 2;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_PERIOD    = 2'd0;
	localparam logic [1:0] REG_QUIET_TIMEOUT = 2'd1;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_RENDER = 2'd1;
	localparam logic [1:0] KIND_DARK   = 2'd2;

	localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(NUM_LEDS - 1);

	// one accepted beat, classified: what frames it causes plus the status snapshot
	typedef struct packed {
		logic        do_render;
		logic        do_dark;
		logic [15:0] leds;
		logic        quiet_now;
		logic [31:0] render_total;
		logic [31:0] delay_total;
		logic [31:0] dark_total;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RENDER,
		BK_DARK
	} back_state_t;

	// each rev bar LED is lit by exactly one bar position (positions never overlap)
	typedef struct packed {
		logic [3:0] pos;
		logic [7:0] red;
		logic [7:0] green;
	} led_src_t;

	function automatic led_src_t led_src(input logic [LED_IDX_W-1:0] idx);
		led_src_t s;
		unique case (idx)
			4'd0:    s = '{pos: 4'd0, red: 8'd0,   green: 8'd255};
			4'd1:    s = '{pos: 4'd1, red: 8'd7,   green: 8'd56};
			4'd2:    s = '{pos: 4'd1, red: 8'd23,  green: 8'd167};
			4'd3:    s = '{pos: 4'd2, red: 8'd31,  green: 8'd96};
			4'd4:    s = '{pos: 4'd2, red: 8'd31,  green: 8'd95};
			4'd5:    s = '{pos: 4'd3, red: 8'd71,  green: 8'd120};
			4'd6:    s = '{pos: 4'd3, red: 8'd23,  green: 8'd39};
			4'd7:    s = '{pos: 4'd4, red: 8'd127, green: 8'd128};
			4'd8:    s = '{pos: 4'd5, red: 8'd39,  green: 8'd24};
			4'd9:    s = '{pos: 4'd5, red: 8'd119, green: 8'd71};
			4'd10:   s = '{pos: 4'd6, red: 8'd95,  green: 8'd32};
			4'd11:   s = '{pos: 4'd6, red: 8'd95,  green: 8'd31};
			4'd12:   s = '{pos: 4'd7, red: 8'd167, green: 8'd24};
			4'd13:   s = '{pos: 4'd7, red: 8'd55,  green: 8'd7};
			4'd14:   s = '{pos: 4'd8, red: 8'd255, green: 8'd0};
			default: s = '{pos: 4'd0, red: 8'd0,   green: 8'd0};
		endcase
		return s;
	endfunction

endpackage

>>> design/rblc_front.sv
`timescale 1ns / 1ps
// Front end: config registers, held command, timers and counters; turns each beat into a job.
// Depends on rblc_pkg.
module rblc_front import rblc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [13:0] wr_data,
	input  logic        accept,
	input  logic        mode,
	input  logic [15:0] led_bits,
	input  logic [23:0] display_bytes,
	output job_t        job
);

	logic [9:0]  min_period_q;
	logic [13:0] quiet_timeout_q;
	logic [15:0] held_leds_q,  held_leds_n;
	logic [23:0] held_disp_q,  held_disp_n;
	logic        dirty_q,      dirty_n;
	logic        quiet_q,      quiet_n;
	logic [15:0] ticks_q,      ticks_n;
	logic [9:0]  render_cd_q,  render_cd_n;
	logic [13:0] quiet_cd_q,   quiet_cd_n;
	logic [31:0] rendered_q,   rendered_n;
	logic [31:0] delayed_q,    delayed_n;
	logic [31:0] quiet_cnt_q,  quiet_cnt_n;
	logic        render_go, dark_go, changed;

	assign changed = (led_bits != held_leds_q) || (display_bytes != held_disp_q) || quiet_q;

	always_comb begin
		held_leds_n = held_leds_q;
		held_disp_n = held_disp_q;
		dirty_n     = dirty_q;
		quiet_n     = quiet_q;
		ticks_n     = ticks_q;
		render_cd_n = render_cd_q;
		quiet_cd_n  = quiet_cd_q;
		rendered_n  = rendered_q;
		delayed_n   = delayed_q;
		quiet_cnt_n = quiet_cnt_q;
		render_go   = 1'b0;
		dark_go     = 1'b0;
		if (!mode) begin
			held_leds_n = led_bits;
			held_disp_n = display_bytes;
			quiet_cd_n  = (quiet_timeout_q == 14'd0) ? 14'd1 : quiet_timeout_q;
			if (changed) begin
				if (ticks_q >= {6'd0, min_period_q}) begin
					render_cd_n = 10'd0;
					render_go   = 1'b1;
				end else begin
					delayed_n   = delayed_q + 32'd1;
					dirty_n     = 1'b1;
					// ticks is below the period here, so it fits in 10 bits
					render_cd_n = min_period_q - ticks_q[9:0];
				end
			end
		end else begin
			if (ticks_q != 16'hFFFF)
				ticks_n = ticks_q + 16'd1;
			if (render_cd_q != 10'd0) begin
				render_cd_n = render_cd_q - 10'd1;
				if (render_cd_q == 10'd1 && dirty_q)
					render_go = 1'b1;
			end
			if (quiet_cd_q != 14'd0) begin
				quiet_cd_n = quiet_cd_q - 14'd1;
				if (quiet_cd_q == 14'd1)
					dark_go = 1'b1;
			end
		end
		if (render_go) begin
			dirty_n    = 1'b0;
			rendered_n = rendered_q + 32'd1;
			quiet_n    = 1'b0;
			ticks_n    = 16'd0;
		end
		if (dark_go) begin
			quiet_cnt_n = quiet_cnt_q + 32'd1;
			quiet_n     = 1'b1;
		end
	end

	always_comb begin
		job.do_render    = render_go;
		job.do_dark      = dark_go;
		job.leds         = held_leds_n;
		job.quiet_now    = quiet_n;
		job.render_total = rendered_n;
		job.delay_total  = delayed_n;
		job.dark_total   = quiet_cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q    <= 10'd17;
			quiet_timeout_q <= 14'd200;
		end else if (wr_en) begin
			if (wr_index == REG_MIN_PERIOD)
				min_period_q <= wr_data[9:0];
			else if (wr_index == REG_QUIET_TIMEOUT)
				quiet_timeout_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_leds_q <= '0;
			held_disp_q <= '0;
			dirty_q     <= 1'b0;
			quiet_q     <= 1'b0;
			ticks_q     <= '0;
			render_cd_q <= '0;
			quiet_cd_q  <= '0;
			rendered_q  <= '0;
			delayed_q   <= '0;
			quiet_cnt_q <= '0;
		end else if (accept) begin
			held_leds_q <= held_leds_n;
			held_disp_q <= held_disp_n;
			dirty_q     <= dirty_n;
			quiet_q     <= quiet_n;
			ticks_q     <= ticks_n;
			render_cd_q <= render_cd_n;
			quiet_cd_q  <= quiet_cd_n;
			rendered_q  <= rendered_n;
			delayed_q   <= delayed_n;
			quiet_cnt_q <= quiet_cnt_n;
		end
	end

endmodule

>>> design/rblc_fifo.sv
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Depends on rblc_pkg (job_t, JOB_DEPTH).
module rblc_fifo import rblc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	input  logic rd,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

	job_t             mem_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full   = (count_q == (PTR_W+1)'(JOB_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(JOB_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (rd)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (wr && !rd)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (rd && !wr)
				count_q <= count_q - (PTR_W+1)'(1);
		end
	end

endmodule

>>> design/rblc_back.sv
`timescale 1ns / 1ps
// Back end: expands each job into status, rendered and dark LED beats, one per cycle
// while the output is popped. Depends on rblc_pkg (job_t, back_state_t, led_src).
module rblc_back import rblc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  job_t                 head_job,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           frame_kind,
	output logic [LED_IDX_W-1:0] led_index,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [6:0]           flag_leds,
	output logic                 last,
	output logic                 quiet_now,
	output logic [31:0]          render_total,
	output logic [31:0]          delay_total,
	output logic [31:0]          dark_total
);

	back_state_t          state_q, state_n;
	logic [LED_IDX_W-1:0] idx_q, idx_n, cur_idx;
	job_t                 job_q, cur_job;
	logic                 out_valid_q, advance, have_item, emit;
	logic [1:0]           it_kind;
	logic [7:0]           it_red, it_green;
	logic [6:0]           it_flags;
	logic                 it_last, lit;
	led_src_t             src;

	// in idle the head of the queue is served directly, so jobs follow without a gap
	assign cur_job   = (state_q == BK_IDLE) ? head_job : job_q;
	assign cur_idx   = (state_q == BK_IDLE) ? '0 : idx_q;
	assign have_item = (state_q != BK_IDLE) || !q_empty;
	assign advance   = !out_valid_q || pop;
	assign emit      = advance && have_item;
	assign q_pop     = emit && (state_q == BK_IDLE);
	assign empty     = !out_valid_q;

	// next state
	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		if (emit) begin
			unique case (state_q)
				BK_IDLE: begin
					idx_n = LED_IDX_W'(1);
					if (head_job.do_render)
						state_n = BK_RENDER;
					else if (head_job.do_dark)
						state_n = BK_DARK;
				end
				BK_RENDER: begin
					if (idx_q == LAST_LED) begin
						idx_n   = '0;
						state_n = job_q.do_dark ? BK_DARK : BK_IDLE;
					end else begin
						idx_n = idx_q + LED_IDX_W'(1);
					end
				end
				BK_DARK: begin
					if (idx_q == LAST_LED) begin
						idx_n   = '0;
						state_n = BK_IDLE;
					end else begin
						idx_n = idx_q + LED_IDX_W'(1);
					end
				end
				default: state_n = BK_IDLE;
			endcase
		end
	end

	assign src = led_src(cur_idx);
	assign lit = cur_job.leds[src.pos];

	// beat contents
	always_comb begin
		it_kind  = KIND_STATUS;
		it_red   = '0;
		it_green = '0;
		it_flags = '0;
		it_last  = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (head_job.do_render) begin
					it_kind  = KIND_RENDER;
					it_red   = lit ? src.red : 8'd0;
					it_green = lit ? src.green : 8'd0;
					it_flags = head_job.leds[15:9];
					it_last  = 1'b0;
				end else if (head_job.do_dark) begin
					it_kind = KIND_DARK;
					it_last = 1'b0;
				end
			end
			BK_RENDER: begin
				it_kind  = KIND_RENDER;
				it_red   = lit ? src.red : 8'd0;
				it_green = lit ? src.green : 8'd0;
				it_flags = job_q.leds[15:9];
				it_last  = (idx_q == LAST_LED) && !job_q.do_dark;
			end
			BK_DARK: begin
				it_kind = KIND_DARK;
				it_last = (idx_q == LAST_LED);
			end
			default: it_kind = KIND_STATUS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			if (advance)
				out_valid_q <= have_item;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= head_job;
		if (emit) begin
			frame_kind   <= it_kind;
			led_index    <= cur_idx;
			red          <= it_red;
			green        <= it_green;
			flag_leds    <= it_flags;
			last         <= it_last;
			quiet_now    <= cur_job.quiet_now;
			render_total <= cur_job.render_total;
			delay_total  <= cur_job.delay_total;
			dark_total   <= cur_job.dark_total;
		end
	end

endmodule

>>> design/rev_bar_led_refresh_controller_core.sv
`timescale 1ns / 1ps
// Top level of the rev bar LED refresh controller: front end, job queue, back end.
// Depends on rblc_pkg, rblc_front, rblc_fifo, rblc_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------------
//  input     | push / full          | mode, led_bits, display_bytes
//  result    | empty / pop          | frame_kind, led_index, red, green, flag_leds,
//            |                      | last, quiet_now, render_total, delay_total,
//            |                      | dark_total
//  config    | wr_en (no wait)      | wr_index, wr_data
//
// An input beat is classified in the cycle it is accepted (all timer and counter state
// updates there) and queued as a job; the queue holds two jobs.
// The back end emits one result beat per cycle while results are popped: 1 beat for a
// status-only input, 15 for one frame, 30 for a rendered plus a dark frame. The back
// end is the rate limit. Result beats sit in an output register; the front keeps
// accepting while it waits, until the job queue is full. Reset loads min period 17 and
// quiet timeout 200 and clears all timers and counters; no clearing pass.
module rev_bar_led_refresh_controller_core import rblc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [1:0]           wr_index,
	input  logic [13:0]          wr_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 mode,
	input  logic [15:0]          led_bits,
	input  logic [23:0]          display_bytes,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           frame_kind,
	output logic [LED_IDX_W-1:0] led_index,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [6:0]           flag_leds,
	output logic                 last,
	output logic                 quiet_now,
	output logic [31:0]          render_total,
	output logic [31:0]          delay_total,
	output logic [31:0]          dark_total
);

	job_t new_job, head_job;
	logic accept, q_empty, q_pop;

	// front state only moves on an accepted beat; it waits on the back end only via full
	assign accept = push && !full;

	rblc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.accept        (accept),
		.mode          (mode),
		.led_bits      (led_bits),
		.display_bytes (display_bytes),
		.job           (new_job)
	);

	rblc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (new_job),
		.rd     (q_pop),
		.rd_job (head_job),
		.full   (full),
		.empty  (q_empty)
	);

	rblc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.frame_kind   (frame_kind),
		.led_index    (led_index),
		.red          (red),
		.green        (green),
		.flag_leds    (flag_leds),
		.last         (last),
		.quiet_now    (quiet_now),
		.render_total (render_total),
		.delay_total  (delay_total),
		.dark_total   (dark_total)
	);

endmodule
